// File: design/pidt_pkg.sv
`default_nettype none

package pidt_pkg;

   // Number format and storage widths
   localparam int DATA_WIDTH      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int INTEGRAL_WIDTH  = 48;
   localparam int TOL_WIDTH       = 31;
   localparam int TIME_WIDTH      = 32;
   localparam int MS_PER_S        = 1000;
   localparam int CSR_INDEX_WIDTH = 3;

   // Shared multiply / divide unit sizing
   localparam int A_WIDTH    = INTEGRAL_WIDTH;
   localparam int B_WIDTH    = DATA_WIDTH + 1;
   localparam int PROD_WIDTH = A_WIDTH + B_WIDTH;
   localparam int DIV_WIDTH  = 64;
   localparam int CNT_WIDTH  = $clog2(DIV_WIDTH);

   // Reciprocal of MS_PER_S: ceil(2^RECIP_SHIFT / MS_PER_S), so that
   // floor(x * RECIP_MS_PER_S / 2^RECIP_SHIFT) equals x / MS_PER_S for x below 2^63
   localparam logic [DIV_WIDTH-1:0] RECIP_MS_PER_S = 64'd9444732965739290428;
   localparam int                   RECIP_SHIFT    = 73;

   localparam logic signed [DATA_WIDTH-1:0] OUT_LIMIT_RESET =
      DATA_WIDTH'(255 << FRAC_BITS);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_TARGET,
      CSR_TOLERANCE,
      CSR_OUT_MIN,
      CSR_OUT_MAX
   } csr_index_type;

   typedef struct packed {
      logic signed [A_WIDTH-1:0] a;
      logic signed [B_WIDTH-1:0] b;
      logic                      shift_en;
      logic                      div_en;
      logic                      recip_en;
      logic [TIME_WIDTH-1:0]     divisor;
      logic                      wide;
   } scale_cmd_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_MUL,
      U_DIV,
      U_RECIP,
      U_DONE
   } unit_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_FIRST,
      ST_INC,
      ST_INTEG,
      ST_DER,
      ST_PTERM,
      ST_ITERM,
      ST_DTERM,
      ST_SUM,
      ST_OUT
   } state_type;

   // Clamp a wide sum to [lo, hi]; below lo wins over above hi
   function automatic logic signed [DATA_WIDTH-1:0] clamp_out(
      input logic signed [DATA_WIDTH+1:0] v,
      input logic signed [DATA_WIDTH-1:0] lo,
      input logic signed [DATA_WIDTH-1:0] hi);
      logic signed [DATA_WIDTH+1:0] lo_x;
      logic signed [DATA_WIDTH+1:0] hi_x;
      logic signed [DATA_WIDTH-1:0] r;
      lo_x = (DATA_WIDTH+2)'(lo);
      hi_x = (DATA_WIDTH+2)'(hi);
      if (v < lo_x) begin
         r = lo;
      end else if (v > hi_x) begin
         r = hi;
      end else begin
         r = v[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/pidt_req_if.sv
`default_nettype none

interface pidt_req_if import pidt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic signed [DATA_WIDTH-1:0] measured_value;
   logic [TIME_WIDTH-1:0]        time_ms;

   modport source (output valid, output req_type, output measured_value, output time_ms,
                   input ready);
   modport sink (input valid, input req_type, input measured_value, input time_ms,
                 output ready);
endinterface

`default_nettype wire

// File: design/pidt_rsp_if.sv
`default_nettype none

interface pidt_rsp_if import pidt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] drive;
   logic                         at_setpoint;
   logic                         repeated;

   modport source (output valid, output drive, output at_setpoint, output repeated,
                   input ready);
   modport sink (input valid, input drive, input at_setpoint, input repeated,
                 output ready);
endinterface

`default_nettype wire

// File: design/pid_controller_timed.sv
// Steps: a full control sample runs a divide and a reciprocal multiply on the shared unit,
// and three multiplies; a first sample runs a single multiply; a restart or a zero-elapsed
// sample uses the unit not at all.
// Throughput: one word at a time; the next word is taken once the result is taken.
// Reset (synchronous, active high): limits to +/-255.0, gains, target and tolerance
// to zero, integral, history and held output cleared, first sample pending.
`default_nettype none

module pid_controller_timed import pidt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   pidt_req_if.sink                   req_ch,
   pidt_rsp_if.source                 rsp_ch,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata
);

   state_type state_ff, state_in;

   // Configuration
   logic signed [DATA_WIDTH-1:0]     gain_p_ff, gain_i_ff, gain_d_ff, target_ff;
   logic [TOL_WIDTH-1:0]             tolerance_ff;
   logic signed [DATA_WIDTH-1:0]     out_min_ff, out_max_ff;

   // Controller state
   logic signed [INTEGRAL_WIDTH-1:0] integral_ff;
   logic signed [DATA_WIDTH-1:0]     prev_err_ff;
   logic [TIME_WIDTH-1:0]            last_time_ff;
   logic signed [DATA_WIDTH-1:0]     held_ff;
   logic                             first_ff;

   // Per-sample working registers
   logic                             type_ff;
   logic signed [DATA_WIDTH-1:0]     meas_ff;
   logic [TIME_WIDTH-1:0]            time_ff;
   logic signed [DATA_WIDTH-1:0]     err_ff;
   logic                             at_ff;
   logic                             rep_ff;
   logic [TIME_WIDTH-1:0]            ms_ff;
   logic signed [INTEGRAL_WIDTH-1:0] inc_ff;
   logic signed [DATA_WIDTH-1:0]     deriv_ff, p_ff, i_ff, d_ff;

   logic signed [DATA_WIDTH:0]       raw;
   logic [DATA_WIDTH:0]              raw_abs;
   logic signed [DATA_WIDTH-1:0]     err_sat;
   logic [TIME_WIDTH-1:0]            ms_now;
   logic signed [DATA_WIDTH:0]       diff;
   logic signed [INTEGRAL_WIDTH:0]   int_sum;
   logic signed [INTEGRAL_WIDTH-1:0] int_sat;
   logic signed [DATA_WIDTH+1:0]     pid_sum;
   logic signed [DATA_WIDTH+1:0]     first_term;

   logic                             accept;
   logic                             u_start;
   logic                             u_done;
   scale_cmd_type                    u_cmd;
   logic signed [A_WIDTH-1:0]        u_result;

   pidt_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (u_start),
      .cmd    (u_cmd),
      .done   (u_done),
      .result (u_result)
   );

   // Error, tolerance check, elapsed time and saturating sums
   always_comb begin
      raw     = (DATA_WIDTH+1)'(target_ff) - (DATA_WIDTH+1)'(meas_ff);
      raw_abs = raw[DATA_WIDTH] ? (DATA_WIDTH+1)'(-raw) : (DATA_WIDTH+1)'(raw);
      if (raw[DATA_WIDTH] != raw[DATA_WIDTH-1]) begin
         err_sat = raw[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                   : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
         err_sat = raw[DATA_WIDTH-1:0];
      end
      ms_now  = time_ff - last_time_ff;
      diff    = (DATA_WIDTH+1)'(err_ff) - (DATA_WIDTH+1)'(prev_err_ff);
      int_sum = (INTEGRAL_WIDTH+1)'(integral_ff) + (INTEGRAL_WIDTH+1)'(inc_ff);
      if (int_sum[INTEGRAL_WIDTH] != int_sum[INTEGRAL_WIDTH-1]) begin
         int_sat = int_sum[INTEGRAL_WIDTH] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                                           : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
      end else begin
         int_sat = int_sum[INTEGRAL_WIDTH-1:0];
      end
      pid_sum    = (DATA_WIDTH+2)'(p_ff) + (DATA_WIDTH+2)'(i_ff) + (DATA_WIDTH+2)'(d_ff);
      first_term = (DATA_WIDTH+2)'($signed(u_result[DATA_WIDTH-1:0]));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_ERR;
         end
         ST_ERR: begin
            if (type_ff) begin
               state_in = ST_OUT;
            end else if (first_ff) begin
               state_in = ST_FIRST;
            end else if (ms_now == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_INC;
            end
         end
         ST_FIRST: begin
            if (u_done) state_in = ST_OUT;
         end
         ST_INC: begin
            if (u_done) state_in = ST_INTEG;
         end
         ST_INTEG: state_in = ST_DER;
         ST_DER: begin
            if (u_done) state_in = ST_PTERM;
         end
         ST_PTERM: begin
            if (u_done) state_in = ST_ITERM;
         end
         ST_ITERM: begin
            if (u_done) state_in = ST_DTERM;
         end
         ST_DTERM: begin
            if (u_done) state_in = ST_SUM;
         end
         ST_SUM: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshakes and the shared unit's command
   always_comb begin
      req_ch.ready       = (state_ff == ST_IDLE);
      rsp_ch.valid       = (state_ff == ST_OUT);
      rsp_ch.drive       = held_ff;
      rsp_ch.at_setpoint = at_ff;
      rsp_ch.repeated    = rep_ff;
      accept             = req_ch.valid && (state_ff == ST_IDLE);

      u_start        = 1'b0;
      u_cmd.a        = A_WIDTH'(err_ff);
      u_cmd.b        = B_WIDTH'(gain_p_ff);
      u_cmd.shift_en = 1'b1;
      u_cmd.div_en   = 1'b0;
      u_cmd.recip_en = 1'b0;
      u_cmd.divisor  = ms_ff;
      u_cmd.wide     = 1'b0;
      case (state_ff)
         ST_FIRST, ST_PTERM: begin
            u_start = 1'b1;
         end
         ST_INC: begin
            u_start        = 1'b1;
            u_cmd.b        = B_WIDTH'(ms_ff);
            u_cmd.shift_en = 1'b0;
            u_cmd.recip_en = 1'b1;
            u_cmd.wide     = 1'b1;
         end
         ST_DER: begin
            u_start        = 1'b1;
            u_cmd.a        = A_WIDTH'(diff);
            u_cmd.b        = B_WIDTH'(MS_PER_S);
            u_cmd.shift_en = 1'b0;
            u_cmd.div_en   = 1'b1;
         end
         ST_ITERM: begin
            u_start = 1'b1;
            u_cmd.a = integral_ff;
            u_cmd.b = B_WIDTH'(gain_i_ff);
         end
         ST_DTERM: begin
            u_start = 1'b1;
            u_cmd.a = A_WIDTH'(deriv_ff);
            u_cmd.b = B_WIDTH'(gain_d_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes and controller state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         target_ff    <= '0;
         tolerance_ff <= '0;
         out_min_ff   <= -OUT_LIMIT_RESET;
         out_max_ff   <= OUT_LIMIT_RESET;
         integral_ff  <= '0;
         prev_err_ff  <= '0;
         last_time_ff <= '0;
         held_ff      <= '0;
         first_ff     <= 1'b1;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_GAIN_P: gain_p_ff <= csr_wdata;
               CSR_GAIN_I: gain_i_ff <= csr_wdata;
               CSR_GAIN_D: gain_d_ff <= csr_wdata;
               CSR_TARGET: begin
                  target_ff   <= csr_wdata;
                  integral_ff <= '0;
                  first_ff    <= 1'b1;
               end
               CSR_TOLERANCE: tolerance_ff <= csr_wdata[TOL_WIDTH-1:0];
               CSR_OUT_MIN: begin
                  out_min_ff <= csr_wdata;
                  held_ff    <= clamp_out((DATA_WIDTH+2)'(held_ff), csr_wdata, out_max_ff);
               end
               CSR_OUT_MAX: begin
                  out_max_ff <= csr_wdata;
                  held_ff    <= clamp_out((DATA_WIDTH+2)'(held_ff), out_min_ff, csr_wdata);
               end
               default: begin
               end
            endcase
         end
         case (state_ff)
            ST_ERR: begin
               if (type_ff) begin
                  integral_ff <= '0;
                  prev_err_ff <= '0;
                  held_ff     <= '0;
                  first_ff    <= 1'b1;
               end
            end
            ST_FIRST: begin
               if (u_done) begin
                  held_ff      <= clamp_out(first_term, out_min_ff, out_max_ff);
                  prev_err_ff  <= err_ff;
                  last_time_ff <= time_ff;
                  first_ff     <= 1'b0;
               end
            end
            ST_INTEG: integral_ff <= int_sat;
            ST_SUM: begin
               held_ff      <= clamp_out(pid_sum, out_min_ff, out_max_ff);
               prev_err_ff  <= err_ff;
               last_time_ff <= time_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Capture the word and the intermediate terms
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               type_ff <= req_ch.req_type;
               meas_ff <= req_ch.measured_value;
               time_ff <= req_ch.time_ms;
            end
         end
         ST_ERR: begin
            err_ff <= err_sat;
            at_ff  <= raw_abs <= (DATA_WIDTH+1)'(tolerance_ff);
            ms_ff  <= ms_now;
            rep_ff <= !type_ff && !first_ff && (ms_now == '0);
         end
         ST_INC: begin
            if (u_done) inc_ff <= u_result;
         end
         ST_DER: begin
            if (u_done) deriv_ff <= u_result[DATA_WIDTH-1:0];
         end
         ST_PTERM: begin
            if (u_done) p_ff <= u_result[DATA_WIDTH-1:0];
         end
         ST_ITERM: begin
            if (u_done) i_ff <= u_result[DATA_WIDTH-1:0];
         end
         ST_DTERM: begin
            if (u_done) d_ff <= u_result[DATA_WIDTH-1:0];
         end
         default: begin
         end
      endcase
   end

   // A taken word blocks the input until its result is delivered
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("input taken again while a word is in work");

   // The shared unit finishes only while a step still waits on it
   assert property (@(posedge clock) disable iff (reset)
      u_done |-> u_start)
      else $error("unit result with no step waiting");

   // A computed output stays within ordered limits
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_ch.valid) && !type_ff && (out_min_ff <= out_max_ff))
         |-> (held_ff >= out_min_ff && held_ff <= out_max_ff))
      else $error("held output outside limits");

endmodule

`default_nettype wire

// File: design/pidt_scale.sv
`default_nettype none

// Shift-add multiply, then an optional restoring divide or a shift-add multiply
// by the reciprocal of MS_PER_S, then saturate:
// result = sat(trunc(a * b [>> FRAC_BITS] [/ divisor | / MS_PER_S]))
module pidt_scale import pidt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  scale_cmd_type             cmd,
   output logic                      done,
   output logic signed [A_WIDTH-1:0] result
);

   unit_state_type          state_ff, state_in;
   logic                    neg_ff;
   logic [A_WIDTH-1:0]      amag_ff;
   logic [B_WIDTH-1:0]      bmag_ff;
   logic [PROD_WIDTH-1:0]   prod_ff;
   logic [DIV_WIDTH-1:0]    quo_ff;
   logic [TIME_WIDTH-1:0]   rem_ff;
   logic [DIV_WIDTH-1:0]    recip_ff;
   logic [CNT_WIDTH-1:0]    cnt_ff;
   logic                    shift_en_ff;
   logic                    div_en_ff;
   logic                    recip_en_ff;
   logic                    wide_ff;
   logic [TIME_WIDTH-1:0]   divisor_ff;

   logic [A_WIDTH:0]        upper;
   logic [PROD_WIDTH-1:0]   prod_in;
   logic [TIME_WIDTH:0]     trial;
   logic [TIME_WIDTH:0]     trial_diff;
   logic                    fits;
   logic [DIV_WIDTH:0]      recip_sum;
   logic [PROD_WIDTH-1:0]   mag_sel;
   logic [PROD_WIDTH-1:0]   lim;
   logic [PROD_WIDTH-1:0]   capped;
   logic [PROD_WIDTH-1:0]   signed_res;

   // One multiplier bit and one quotient bit per cycle
   always_comb begin
      upper      = {1'b0, prod_ff[PROD_WIDTH-1:B_WIDTH]}
                   + (bmag_ff[0] ? {1'b0, amag_ff} : {(A_WIDTH+1){1'b0}});
      prod_in    = {upper, prod_ff[B_WIDTH-1:1]};
      trial      = {rem_ff, quo_ff[DIV_WIDTH-1]};
      fits       = trial >= {1'b0, divisor_ff};
      trial_diff = trial - {1'b0, divisor_ff};
      // Reciprocal step: add the product if this reciprocal bit is set, then shift right by one bit
      recip_sum  = {1'b0, recip_ff}
                   + (RECIP_MS_PER_S[cnt_ff] ? {1'b0, quo_ff} : {(DIV_WIDTH+1){1'b0}});
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE: begin
            if (start) state_in = U_MUL;
         end
         U_MUL: begin
            if (cnt_ff == CNT_WIDTH'(B_WIDTH - 1)) begin
               state_in = div_en_ff ? U_DIV : (recip_en_ff ? U_RECIP : U_DONE);
            end
         end
         U_DIV: begin
            if (cnt_ff == CNT_WIDTH'(DIV_WIDTH - 1)) state_in = U_DONE;
         end
         U_RECIP: begin
            if (cnt_ff == CNT_WIDTH'(DIV_WIDTH - 1)) state_in = U_DONE;
         end
         U_DONE: state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   // Outputs: saturate the magnitude, then apply the sign
   always_comb begin
      done = (state_ff == U_DONE);
      if (recip_en_ff) begin
         mag_sel = PROD_WIDTH'(recip_ff >> (RECIP_SHIFT - DIV_WIDTH));
      end else if (div_en_ff) begin
         mag_sel = PROD_WIDTH'(quo_ff);
      end else if (shift_en_ff) begin
         mag_sel = prod_ff >> FRAC_BITS;
      end else begin
         mag_sel = prod_ff;
      end
      lim = (PROD_WIDTH'(1) << (wide_ff ? INTEGRAL_WIDTH - 1 : DATA_WIDTH - 1))
            - PROD_WIDTH'(1) + PROD_WIDTH'(neg_ff);
      capped     = (mag_sel > lim) ? lim : mag_sel;
      signed_res = neg_ff ? (~capped + PROD_WIDTH'(1)) : capped;
      result     = signed_res[A_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operand load, multiply, divide and reciprocal steps
   always_ff @(posedge clock) begin
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               amag_ff     <= cmd.a[A_WIDTH-1] ? A_WIDTH'(-cmd.a) : A_WIDTH'(cmd.a);
               bmag_ff     <= cmd.b[B_WIDTH-1] ? B_WIDTH'(-cmd.b) : B_WIDTH'(cmd.b);
               neg_ff      <= cmd.a[A_WIDTH-1] ^ cmd.b[B_WIDTH-1];
               shift_en_ff <= cmd.shift_en;
               div_en_ff   <= cmd.div_en;
               recip_en_ff <= cmd.recip_en;
               wide_ff     <= cmd.wide;
               divisor_ff  <= cmd.divisor;
               prod_ff     <= '0;
               cnt_ff      <= '0;
            end
         end
         U_MUL: begin
            prod_ff  <= prod_in;
            bmag_ff  <= bmag_ff >> 1;
            quo_ff   <= prod_in[DIV_WIDTH-1:0];
            rem_ff   <= '0;
            recip_ff <= '0;
            cnt_ff   <= (cnt_ff == CNT_WIDTH'(B_WIDTH - 1)) ? '0 : cnt_ff + CNT_WIDTH'(1);
         end
         U_DIV: begin
            quo_ff <= {quo_ff[DIV_WIDTH-2:0], fits};
            rem_ff <= fits ? trial_diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
            cnt_ff <= cnt_ff + CNT_WIDTH'(1);
         end
         U_RECIP: begin
            recip_ff <= recip_sum[DIV_WIDTH:1];
            cnt_ff   <= cnt_ff + CNT_WIDTH'(1);
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// File: dv/pidt_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module pidt_checker import pidt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pidt_req_if                   req_ch,
   pidt_rsp_if                   rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    words_taken
);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] drive;
      logic                         at_setpoint;
      logic                         repeated;
   } pid_result_type;

   pid_result_type expected_results[$];

   // controller image
   longint kp, ki, kd, setpoint, tol, lim_lo, lim_hi;
   longint integ, last_err, held;
   logic [31:0] stamp;
   bit first_sample;

   function automatic longint sat_to(longint x, int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
   endfunction

   // exact trunc(a*b / 2^shift / div), saturated to w bits
   function automatic longint mul_div_sat(longint a, longint b, int shift, longint div, int w);
      logic signed [127:0] prod;
      logic signed [127:0] q;
      prod = 128'(signed'(a)) * 128'(signed'(b));
      q = prod;
      if (shift > 0) begin
         // truncate toward zero
         if (q < 0) q = -((-q) >>> shift);
         else q = q >>> shift;
      end
      if (div > 1) q = q / 128'(signed'(div));
      if (q > 128'(signed'((longint'(1) << (w - 1)) - 1)))
         return (longint'(1) << (w - 1)) - 1;
      if (q < -128'(signed'(longint'(1) << (w - 1))))
         return -(longint'(1) << (w - 1));
      return longint'(q);
   endfunction

   function automatic longint limit_drive(longint v);
      if (v < lim_lo) return lim_lo;
      if (v > lim_hi) return lim_hi;
      return v;
   endfunction

   function automatic void reset_image();
      kp = 0; ki = 0; kd = 0; setpoint = 0; tol = 0;
      lim_lo = -16711680; lim_hi = 16711680;
      integ = 0; last_err = 0; held = 0; stamp = '0; first_sample = 1;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] v);
      case (idx)
         CSR_GAIN_P: kp = longint'(signed'(v));
         CSR_GAIN_I: ki = longint'(signed'(v));
         CSR_GAIN_D: kd = longint'(signed'(v));
         CSR_TARGET: begin
            setpoint = longint'(signed'(v)); integ = 0; first_sample = 1;
         end
         CSR_TOLERANCE: tol = longint'(v[30:0]);
         CSR_OUT_MIN: begin
            lim_lo = longint'(signed'(v)); held = limit_drive(held);
         end
         CSR_OUT_MAX: begin
            lim_hi = longint'(signed'(v)); held = limit_drive(held);
         end
         default: ;
      endcase
   endfunction

   function automatic pid_result_type control_step(logic restart, logic [31:0] meas_bits,
                                                   logic [31:0] now);
      pid_result_type r;
      longint meas, raw, err, inc, p, i, d, deriv, absraw;
      logic [31:0] ms;
      meas = longint'(signed'(meas_bits));
      raw = setpoint - meas;
      err = sat_to(raw, DATA_WIDTH);
      absraw = raw < 0 ? -raw : raw;
      r.at_setpoint = absraw <= tol;
      r.repeated = 0;
      if (restart) begin
         integ = 0; last_err = 0; held = 0; first_sample = 1;
      end else if (first_sample) begin
         stamp = now; first_sample = 0; last_err = err;
         held = limit_drive(mul_div_sat(kp, err, FRAC_BITS, 1, DATA_WIDTH));
      end else begin
         ms = now - stamp;
         if (ms == 0) begin
            r.repeated = 1;
         end else begin
            inc = mul_div_sat(err, longint'(ms), 0, MS_PER_S, INTEGRAL_WIDTH);
            integ = sat_to(integ + inc, INTEGRAL_WIDTH);
            deriv = mul_div_sat(err - last_err, MS_PER_S, 0, longint'(ms), DATA_WIDTH);
            p = mul_div_sat(kp, err, FRAC_BITS, 1, DATA_WIDTH);
            i = mul_div_sat(ki, integ, FRAC_BITS, 1, DATA_WIDTH);
            d = mul_div_sat(kd, deriv, FRAC_BITS, 1, DATA_WIDTH);
            held = limit_drive(p + i + d);
            last_err = err;
            stamp = now;
         end
      end
      r.drive = held[31:0];
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      pid_result_type want;
      if (reset) begin
         reset_image();
         expected_results.delete();
         fail_count <= 0;
         words_taken <= 0;
      end else begin
         if (csr_write_en) apply_csr(csr_index, csr_wdata);
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(control_step(req_ch.req_type, req_ch.measured_value,
                                                    req_ch.time_ms));
            words_taken <= words_taken + 1;
         end
         // compare against the oldest expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected result drive=%0d", rsp_ch.drive);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.drive !== rsp_ch.drive || want.at_setpoint !== rsp_ch.at_setpoint ||
                   want.repeated !== rsp_ch.repeated) begin
                  if (fail_count < 10)
                     $display("mismatch: exp drive=%0d at=%0b rep=%0b got drive=%0d at=%0b rep=%0b",
                              want.drive, want.at_setpoint, want.repeated,
                              rsp_ch.drive, rsp_ch.at_setpoint, rsp_ch.repeated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: dv/pid_controller_timed_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module pid_controller_timed_tb;
   import pidt_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [DATA_WIDTH-1:0] csr_wdata = '0;
   int fail_count, pending_count, words_taken;
   int sender_idle_pct = 0, receiver_idle_pct = 0;
   bit hold_receiver = 0;
   int idle_cycles = 0;
   logic [31:0] clock_ms = 0;

   pidt_req_if req_ch ();
   pidt_rsp_if rsp_ch ();

   pid_controller_timed DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pidt_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count), .words_taken(words_taken)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else rsp_ch.ready <= !hold_receiver && ($urandom_range(99) >= receiver_idle_pct);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   // one register write, then the write enable is dropped before the task returns
   task automatic write_csr(csr_index_type idx, logic [31:0] v);
      csr_write_en <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_write_en <= 0;
      @(posedge clock);
   endtask

   // send one word, with a random gap in front of it; valid stays up after the handshake
   task automatic send_word(logic restart, logic [31:0] meas, logic [31:0] stamp_ms);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.req_type <= restart;
      req_ch.measured_value <= meas; req_ch.time_ms <= stamp_ms;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // drop valid and let the block drain before touching registers
   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(200000) - 100000;
         3: return $urandom_range(40000000) - 20000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(1 << 17) - (1 << 16);
         default: return $urandom_range(1 << 20) - (1 << 19);
      endcase
   endfunction

   // random controller settings, extremes at times
   task automatic random_settings(bit wide);
      write_csr(CSR_GAIN_P, pick_gain());
      write_csr(CSR_GAIN_I, pick_gain());
      write_csr(CSR_GAIN_D, pick_gain());
      write_csr(CSR_TARGET, pick_value());
      write_csr(CSR_TOLERANCE, wide ? 32'h7fffffff : $urandom_range(1 << 20));
      if (wide) begin
         write_csr(CSR_OUT_MIN, 32'h80000000);
         write_csr(CSR_OUT_MAX, 32'h7fffffff);
      end else begin
         write_csr(CSR_OUT_MIN, pick_value());
         write_csr(CSR_OUT_MAX, pick_value());
      end
   endtask

   task automatic random_burst(int count);
      logic [31:0] step;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(19))
            0: step = 0;
            1: step = $urandom;
            2: step = 32'hffffffff;
            default: step = $urandom_range(1, 50);
         endcase
         clock_ms = clock_ms + step;
         send_word($urandom_range(29) == 0, pick_value(), clock_ms);
      end
   endtask

   initial begin
      req_ch.valid <= 0; req_ch.req_type <= 0; req_ch.measured_value <= 0;
      req_ch.time_ms <= 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, first sample, zero elapsed, restart, extremes
      send_word(0, 32'h00010000, 32'd100);
      send_word(0, 32'h00010000, 32'd100);
      send_word(0, 32'h7fffffff, 32'd0);
      send_word(1, 32'h80000000, 32'hffffffff);
      drain();
      write_csr(CSR_GAIN_P, 32'h00010000);
      write_csr(CSR_GAIN_I, 32'h00008000);
      write_csr(CSR_GAIN_D, 32'h00000100);
      write_csr(CSR_TARGET, 32'h00050000);
      write_csr(CSR_TOLERANCE, 32'h00010000);
      send_word(0, 32'h00040000, 32'd10);
      send_word(0, 32'h00048000, 32'd20);
      send_word(0, 32'h00050000, 32'd20);
      send_word(0, 32'h80000000, 32'd21);
      send_word(0, 32'h7fffffff, 32'd5);
      send_word(0, 32'h00000000, 32'hffffffff);
      send_word(1, 32'h00050000, 32'd7);
      send_word(0, 32'h00010000, 32'd8);
      send_word(0, 32'h00010000, 32'd9);
      drain();
      write_csr(CSR_GAIN_P, 32'h7fffffff);
      write_csr(CSR_GAIN_I, 32'h80000000);
      write_csr(CSR_GAIN_D, 32'h7fffffff);
      write_csr(CSR_TARGET, 32'h80000000);
      write_csr(CSR_TOLERANCE, 32'h7fffffff);
      send_word(0, 32'h7fffffff, 32'd1);
      send_word(0, 32'h80000000, 32'd2);
      send_word(0, 32'h7fffffff, 32'd1002);
      drain();
      // limit writes clamp the held output; inverted limits
      write_csr(CSR_OUT_MIN, 32'h00100000);
      write_csr(CSR_OUT_MAX, 32'hfff00000);
      send_word(0, 32'h7fffffff, 32'd1002);
      send_word(0, 32'h00000000, 32'd3000);
      drain();

      // random phases under three idling patterns
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 73 : 0;
         receiver_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 25 : 0;
         for (int s = 0; s < 5; s++) begin
            random_settings(s == 4);
            if (ph == 2 && s == 0) begin
               // hold the receiver off while words keep coming
               fork
                  begin
                     hold_receiver = 1;
                     repeat (3000) @(posedge clock);
                     hold_receiver = 0;
                  end
                  random_burst(10);
               join
            end
            random_burst(100);
            drain();
         end
      end
      write_csr(CSR_OUT_MIN, 32'hff010000);
      write_csr(CSR_OUT_MAX, 32'h00ff0000);
      random_burst(20);
      drain();

      $display("covered %0d control words over 15 random settings and directed edge cases",
               words_taken);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
design/pidt_pkg.sv
design/pidt_req_if.sv
design/pidt_rsp_if.sv
design/pidt_scale.sv
design/pid_controller_timed.sv
dv/pidt_checker.sv
dv/pid_controller_timed_tb.sv
